>>> design/nkj_pkg.sv
// ----------------------------------------------------------------------------
// nkj_pkg
// Shared types and constants for the nearest-key joint lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package nkj_pkg;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned KEY_AXES    = 3;
	localparam int unsigned AXES_HELD   = 3;

	localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned JOINT_W = 16;
	localparam int unsigned MATCH_W = 10;
	localparam int unsigned SQ_W    = 2 * KEY_W;
	localparam int unsigned DIST_W  = SQ_W + 2;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_MATCH = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [KEY_W-1:0]   key_x;
		logic signed [KEY_W-1:0]   key_y;
		logic signed [KEY_W-1:0]   key_z;
		logic [JOINT_W-1:0]        joint_a;
		logic [JOINT_W-1:0]        joint_b;
		logic [JOINT_W-1:0]        joint_c;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [MATCH_W-1:0] match_index;
		logic [JOINT_W-1:0] out_joint_a;
		logic [JOINT_W-1:0] out_joint_b;
		logic [JOINT_W-1:0] out_joint_c;
	} rsp_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] x;
		logic signed [KEY_W-1:0] y;
		logic signed [KEY_W-1:0] z;
	} key_t;

	typedef struct packed {
		logic [JOINT_W-1:0] a;
		logic [JOINT_W-1:0] b;
		logic [JOINT_W-1:0] c;
	} joint_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		key_t             key;
		joint_t           joint;
	} tbl_wr_t;

	typedef struct packed {
		logic             key_en;
		logic [IDX_W-1:0] key_addr;
		logic             joint_en;
		logic [IDX_W-1:0] joint_addr;
	} tbl_rd_t;

	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sq_sum;
	} dist_out_t;

endpackage

`default_nettype wire

>>> design/nkj_table.sv
// ----------------------------------------------------------------------------
// nkj_table
// Entry storage: a key memory and a joint memory, one write port and one
// registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module nkj_table (
	input  wire logic             clk,
	input  wire nkj_pkg::tbl_wr_t wr,
	input  wire nkj_pkg::tbl_rd_t rd,
	output nkj_pkg::key_t         key_rd,
	output nkj_pkg::joint_t       joint_rd
);
	import nkj_pkg::*;

	key_t   key_mem   [TABLE_DEPTH];
	joint_t joint_mem [TABLE_DEPTH];
	key_t   key_rd_q;
	joint_t joint_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr]   <= wr.key;
			joint_mem[wr.addr] <= wr.joint;
		end
		if (rd.key_en) begin
			key_rd_q <= key_mem[rd.key_addr];
		end
		if (rd.joint_en) begin
			joint_rd_q <= joint_mem[rd.joint_addr];
		end
	end

	assign key_rd   = key_rd_q;
	assign joint_rd = joint_rd_q;

endmodule

`default_nettype wire

>>> design/nkj_dist.sv
// ----------------------------------------------------------------------------
// nkj_dist
// Distance pipeline: per-axis absolute difference, square, then the sum of
// the squares, one entry entering per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nkj_dist (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      issue,
	input  wire logic [nkj_pkg::IDX_W-1:0] issue_idx,
	input  wire nkj_pkg::key_t             key_rd,
	input  wire nkj_pkg::key_t             query,
	output nkj_pkg::dist_out_t             result
);
	import nkj_pkg::*;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3, idx_s4;
	logic [KEY_W-1:0]  mag_s2 [AXES_HELD];
	logic [SQ_W-1:0]   sq_s3  [AXES_HELD];
	logic [DIST_W-1:0] dist_s4;

	logic signed [KEY_W-1:0] ent_ax [AXES_HELD];
	logic signed [KEY_W-1:0] qry_ax [AXES_HELD];
	logic [KEY_W-1:0]        mag    [AXES_HELD];

	assign ent_ax[0] = key_rd.x;
	assign ent_ax[1] = key_rd.y;
	assign ent_ax[2] = key_rd.z;
	assign qry_ax[0] = query.x;
	assign qry_ax[1] = query.y;
	assign qry_ax[2] = query.z;

	// The difference of two 32-bit signed values needs 33 bits, but its
	// magnitude always fits in 32.
	always_comb begin
		logic [KEY_W:0] diff;
		logic [KEY_W:0] neg;
		for (int a = 0; a < AXES_HELD; a++) begin
			diff   = {ent_ax[a][KEY_W-1], ent_ax[a]} - {qry_ax[a][KEY_W-1], qry_ax[a]};
			neg    = -diff;
			mag[a] = diff[KEY_W] ? neg[KEY_W-1:0] : diff[KEY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int a = 0; a < AXES_HELD; a++) begin
			mag_s2[a] <= mag[a];
			// Axes past the configured count do not enter the distance.
			sq_s3[a]  <= (a < KEY_AXES) ? SQ_W'(mag_s2[a] * mag_s2[a]) : '0;
		end
		dist_s4 <= DIST_W'(sq_s3[0]) + DIST_W'(sq_s3[1]) + DIST_W'(sq_s3[2]);
	end

	assign result.valid  = v_s4;
	assign result.busy   = v_s1 | v_s2 | v_s3 | v_s4;
	assign result.idx    = idx_s4;
	assign result.sq_sum = dist_s4;

endmodule

`default_nettype wire

>>> design/nearest_key_joint_lookup.sv
// ----------------------------------------------------------------------------
// nearest_key_joint_lookup
// Inverse-kinematics lookup table with an exact nearest-key search.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load, a clear, an unused action or a
// query on an empty table is accepted; its result is registered and then
// moves to the output register. A query on a table of N entries reads the key
// memory once per entry, one entry per cycle through its single read port;
// the read and distance pipeline then empties into the running minimum, the
// joint memory is read once for the winning entry, and the result passes
// through the result registers. Any result waits further while the output
// register still holds an untaken one. A new item is taken as soon as the
// previous result has moved to the output register, even if that result has
// not yet been taken.
`default_nettype none

module nearest_key_joint_lookup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire nkj_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output nkj_pkg::rsp_item_t      rsp
);
	import nkj_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_JWAIT = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_addr_q;
	logic              have_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	key_t              query_q;
	rsp_item_t         res_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	tbl_wr_t   wr;
	tbl_rd_t   rd;
	key_t      key_rd;
	joint_t    joint_rd;
	dist_out_t dist_res;

	logic       accept;
	logic       full;
	logic       last;
	logic       out_free;
	logic       better;
	logic [1:0] acc_status;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign last      = ((CNT_W'(scan_addr_q) + CNT_W'(1)) == count_q);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign better    = dist_res.valid && (!have_q || (dist_res.sq_sum < best_dist_q));

	always_comb begin
		case (req.action)
			ACT_LOAD:  acc_status = full ? ST_FULL : ST_DONE;
			ACT_QUERY: acc_status = (count_q == '0) ? ST_EMPTY : ST_MATCH;
			default:   acc_status = ST_DONE;
		endcase
	end

	// Loads write at acceptance; scans only run after that, so a read never
	// overlaps a write to the same entry.
	always_comb begin
		wr.en        = accept && (req.action == ACT_LOAD) && !full;
		wr.addr      = count_q[IDX_W-1:0];
		wr.key.x     = req.key_x;
		wr.key.y     = req.key_y;
		wr.key.z     = req.key_z;
		wr.joint.a   = req.joint_a;
		wr.joint.b   = req.joint_b;
		wr.joint.c   = req.joint_c;
		rd.key_en    = (state_q == S_SCAN);
		rd.key_addr  = scan_addr_q;
		rd.joint_en  = (state_q == S_DRAIN) && !dist_res.busy;
		rd.joint_addr = best_idx_q;
	end

	nkj_table u_table (
		.clk      (clk),
		.wr       (wr),
		.rd       (rd),
		.key_rd   (key_rd),
		.joint_rd (joint_rd)
	);

	nkj_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (rd.key_en),
		.issue_idx (scan_addr_q),
		.key_rd    (key_rd),
		.query     (query_q),
		.result    (dist_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_addr_q <= '0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (better) begin
				have_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						case (req.action)
							ACT_LOAD: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_QUERY: begin
								if (count_q != '0) begin
									state_q     <= S_SCAN;
									scan_addr_q <= '0;
									have_q      <= 1'b0;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (last) begin
						state_q <= S_DRAIN;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (!dist_res.busy) begin
						state_q <= S_JWAIT;
					end
				end
				S_JWAIT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q.x <= req.key_x;
			query_q.y <= req.key_y;
			query_q.z <= req.key_z;
			res_q     <= '{status: acc_status, match_index: '0, out_joint_a: '0,
				out_joint_b: '0, out_joint_c: '0};
		end
		if (better) begin
			best_idx_q  <= dist_res.idx;
			best_dist_q <= dist_res.sq_sum;
		end
		if (state_q == S_JWAIT) begin
			res_q.match_index <= MATCH_W'(best_idx_q);
			res_q.out_joint_a <= joint_rd.a;
			res_q.out_joint_b <= joint_rd.b;
			res_q.out_joint_c <= joint_rd.c;
		end
		if ((state_q == S_RESP) && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-key joint lookup table. Loads, queries,
// clears and unused actions go in over a valid/ready channel. A scoreboard
// keeps its own copy of the table, works out the exact nearest entry for each
// query and compares every result field by field. Directed items cover the
// extreme keys, ties and the empty table. Random traffic follows under
// changing idle patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nkj_pkg::*;

	localparam logic [1:0]              ACT_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX    = 32'sh7fff_ffff;
	localparam logic signed [KEY_W-1:0] KEY_ONE    = 32'sh0001_0000;
	localparam logic [JOINT_W-1:0]      JOINT_MAX  = 16'hffff;
	localparam int unsigned             RANDOM_PER_PHASE = 186;

	class lookup_scoreboard;
		key_t        stored_key[TABLE_DEPTH];
		joint_t      stored_joint[TABLE_DEPTH];
		int unsigned fill;
		rsp_item_t   expected_q[$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function logic [DIST_W-1:0] axis_square(logic signed [KEY_W-1:0] a,
				logic signed [KEY_W-1:0] b);
			longint            diff;
			logic [DIST_W-1:0] mag;
			diff = longint'(a) - longint'(b);
			if (diff < 0) begin
				diff = -diff;
			end
			mag = DIST_W'(diff);
			return mag * mag;
		endfunction

		// Exact squared distance; up to three squares of 64 bits, so 66 bits hold it.
		function logic [DIST_W-1:0] key_distance(key_t a, key_t b);
			logic [DIST_W-1:0] sum;
			sum = axis_square(a.x, b.x);
			if (KEY_AXES > 1) begin
				sum += axis_square(a.y, b.y);
			end
			if (KEY_AXES > 2) begin
				sum += axis_square(a.z, b.z);
			end
			return sum;
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t         want;
			key_t              probe;
			logic [DIST_W-1:0] cand_dist;
			logic [DIST_W-1:0] best_dist;
			int unsigned       best;
			int unsigned       i;
			want = '0;
			probe.x = r.key_x;
			probe.y = r.key_y;
			probe.z = r.key_z;
			case (r.action)
				ACT_LOAD: begin
					if (fill >= TABLE_DEPTH) begin
						want.status = ST_FULL;
					end else begin
						stored_key[fill] = probe;
						stored_joint[fill].a = r.joint_a;
						stored_joint[fill].b = r.joint_b;
						stored_joint[fill].c = r.joint_c;
						fill++;
						want.status = ST_DONE;
					end
				end
				ACT_QUERY: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
					end else begin
						best = 0;
						best_dist = key_distance(stored_key[0], probe);
						for (i = 1; i < fill; i++) begin
							cand_dist = key_distance(stored_key[i], probe);
							// Strictly less, so the lowest index keeps a tie.
							if (cand_dist < best_dist) begin
								best = i;
								best_dist = cand_dist;
							end
						end
						want.status = ST_MATCH;
						want.match_index = MATCH_W'(best);
						want.out_joint_a = stored_joint[best].a;
						want.out_joint_b = stored_joint[best].b;
						want.out_joint_c = stored_joint[best].c;
					end
				end
				ACT_CLEAR: begin
					fill = 0;
					want.status = ST_DONE;
				end
				default: begin
					want.status = ST_DONE;
				end
			endcase
			expected_q = {expected_q, want};
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("%0t ns: %s differs: got %0h, expected %0h", $time, what, got, want);
		endtask

		task check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing pending", got, 64'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.match_index !== want.match_index)
				report_mismatch("match_index", got.match_index, want.match_index);
			if (got.out_joint_a !== want.out_joint_a)
				report_mismatch("out_joint_a", got.out_joint_a, want.out_joint_a);
			if (got.out_joint_b !== want.out_joint_b)
				report_mismatch("out_joint_b", got.out_joint_b, want.out_joint_b);
			if (got.out_joint_c !== want.out_joint_c)
				report_mismatch("out_joint_c", got.out_joint_c, want.out_joint_c);
		endtask

		function int unsigned outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	int unsigned      tx_idle_pct = 0;
	int unsigned      rx_idle_pct = 0;
	int unsigned      rx_hold_left = 0;
	lookup_scoreboard sb;

	nearest_key_joint_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Result side: check taken items, then choose ready for the next edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic req_item_t make_req(logic [1:0] action, logic signed [KEY_W-1:0] x,
			logic signed [KEY_W-1:0] y, logic signed [KEY_W-1:0] z,
			logic [JOINT_W-1:0] a, logic [JOINT_W-1:0] b, logic [JOINT_W-1:0] c);
		req_item_t r;
		r.action = action;
		r.key_x = x;
		r.key_y = y;
		r.key_z = z;
		r.joint_a = a;
		r.joint_b = b;
		r.joint_c = c;
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] random_coord();
		case ($urandom_range(9))
			0: begin
				return KEY_MIN;
			end
			1: begin
				return KEY_MAX;
			end
			2: begin
				return '0;
			end
			3, 4, 5: begin
				return $urandom;
			end
			default: begin
				return $signed($urandom) >>> $urandom_range(4, 24);
			end
		endcase
	endfunction

	function automatic logic signed [KEY_W-1:0] nudge();
		if ($urandom_range(1) == 0) begin
			return $signed($urandom_range(16)) - 8;
		end
		return $signed($urandom) >>> $urandom_range(12, 30);
	endfunction

	function automatic logic [JOINT_W-1:0] random_joint();
		case ($urandom_range(7))
			0: begin
				return '0;
			end
			1: begin
				return JOINT_MAX;
			end
			default: begin
				return $urandom_range(65535);
			end
		endcase
	endfunction

	// Mostly loads and queries near stored keys, with clears keeping the table short.
	function automatic req_item_t random_request();
		req_item_t   r;
		key_t        base;
		int unsigned pick;
		int unsigned near_pct;
		r.key_x = random_coord();
		r.key_y = random_coord();
		r.key_z = random_coord();
		r.joint_a = random_joint();
		r.joint_b = random_joint();
		r.joint_c = random_joint();
		pick = $urandom_range(99);
		if ((sb.fill > 40 && pick < 30) || pick < 5) begin
			r.action = ACT_CLEAR;
		end else if (pick < 10) begin
			r.action = ACT_UNUSED;
		end else if (pick < 55) begin
			r.action = ACT_LOAD;
		end else begin
			r.action = ACT_QUERY;
		end
		near_pct = (r.action == ACT_QUERY) ? 70 : (r.action == ACT_LOAD) ? 15 : 0;
		if (sb.fill > 0 && $urandom_range(99) < near_pct) begin
			base = sb.stored_key[$urandom_range(sb.fill - 1)];
			r.key_x = base.x;
			r.key_y = base.y;
			r.key_z = base.z;
			if (r.action == ACT_QUERY && $urandom_range(2) != 0) begin
				r.key_x = base.x + nudge();
				r.key_y = base.y + nudge();
				r.key_z = base.z + nudge();
			end
		end
		return r;
	endfunction

	task automatic req_pause(int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Valid stays high after acceptance; every path that waits goes through
	// req_pause or wait_drained, which lower it first.
	task automatic send_item(req_item_t r);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			req_pause(1);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic run_directed();
		send_item(make_req(ACT_QUERY, '0, '0, '0, '0, '0, '0));
		// Both distances below exceed 64 bits; the second entry is nearer.
		send_item(make_req(ACT_LOAD, KEY_MIN, KEY_MIN, KEY_MIN, '0, '0, '0));
		send_item(make_req(ACT_LOAD, KEY_MAX, KEY_MIN, KEY_MIN, JOINT_MAX, JOINT_MAX, JOINT_MAX));
		send_item(make_req(ACT_QUERY, KEY_MAX, KEY_MAX, KEY_MAX, JOINT_MAX, JOINT_MAX,
			JOINT_MAX));
		send_item(make_req(ACT_QUERY, KEY_MIN, KEY_MIN, KEY_MIN, '0, '0, '0));
		send_item(make_req(ACT_LOAD, '0, '0, '0, 16'h1234, 16'h5678, 16'h9abc));
		send_item(make_req(ACT_LOAD, '0, '0, '0, 16'h1111, 16'h2222, 16'h3333));
		send_item(make_req(ACT_QUERY, '0, '0, '0, '0, '0, '0));
		send_item(make_req(ACT_UNUSED, -1, -1, -1, JOINT_MAX, JOINT_MAX, JOINT_MAX));
		send_item(make_req(ACT_CLEAR, -1, -1, -1, JOINT_MAX, JOINT_MAX, JOINT_MAX));
		send_item(make_req(ACT_QUERY, KEY_ONE, KEY_ONE, KEY_ONE, '0, '0, '0));
		// Two entries at equal distance from the origin.
		send_item(make_req(ACT_LOAD, KEY_ONE, '0, '0, 16'h0a0a, 16'h0b0b, 16'h0c0c));
		send_item(make_req(ACT_LOAD, -KEY_ONE, '0, '0, 16'h1a1a, 16'h1b1b, 16'h1c1c));
		send_item(make_req(ACT_QUERY, '0, '0, '0, '0, '0, '0));
		send_item(make_req(ACT_QUERY, -3 * KEY_ONE, '0, '0, '0, '0, '0));
		// Entries that differ only on the third or only on the second axis.
		send_item(make_req(ACT_LOAD, '0, '0, 5 * KEY_ONE, 16'h0505, 16'h0606, 16'h0707));
		send_item(make_req(ACT_QUERY, '0, '0, 5 * KEY_ONE, '0, '0, '0));
		send_item(make_req(ACT_LOAD, '0, 7 * KEY_ONE, '0, 16'h7070, 16'h8080, 16'h9090));
		send_item(make_req(ACT_QUERY, '0, 7 * KEY_ONE, KEY_ONE, '0, '0, '0));
		send_item(make_req(ACT_LOAD, -1, -1, -1, JOINT_MAX, '0, JOINT_MAX));
		send_item(make_req(ACT_QUERY, -1, -1, -1, '0, '0, '0));
		send_item(make_req(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
	endtask

	initial begin
		int unsigned phase;
		int unsigned n;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 52 : 0;
			rx_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 13 : 0;
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// The receiver holds off while items keep coming, so the block backs up.
				if (phase == 0 && n == 80) begin
					rx_hold_left = 400;
				end
				if (phase == 1 && n == 100) begin
					wait_drained();
				end
				send_item(random_request());
			end
			wait_drained();
		end
		repeat (64) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> nearest_key_joint_lookup.f
design/nkj_pkg.sv
design/nkj_table.sv
design/nkj_dist.sv
design/nearest_key_joint_lookup.sv
tb/tb_top.sv
